[src/gpf_pkg.sv]
// gpf_pkg: types and fixed constants for the grid local peak finder
// used by grid_local_peak_finder_core; depends on nothing else
package gpf_pkg;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 6;
  localparam int PEAK_BITS      = 5;
  localparam int OUT_DATA_BITS  = 16;

  localparam logic [CFG_INDEX_BITS-1:0] REG_ROW_COUNT    = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COLUMN_COUNT = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_ABOVE,
    ST_FLUSH_RD,
    ST_FLUSH
  } gpf_state_t;

endpackage

[src/grid_local_peak_finder_core.sv]
// grid_local_peak_finder_core: four-neighbor local maximum detection on a raster frame
// line memory holds the two most recent rows per column, flag memory the last-row peaks
// depends on gpf_pkg
//
//  channel  | dir | handshake          | payload
//  s_       | in  | s_tvalid/s_tready  | s_tdata: sample
//  m_       | out | m_tvalid/m_tready  | m_tdata: peak_row, peak_column; m_tlast: last_of_run
//  cfg_     | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// a sample is accepted with the line memory read, then decided and written back
// a peak of the row above adds the ABOVE state; the frame-end flush walks the flag memory
// column by column, a read then a flush state each, up to the last flagged column
// output register waits on m_tready; sample intake resumes once the beat is loaded
// synchronous reset; a row or column count write restarts the frame
module grid_local_peak_finder_core
  import gpf_pkg::*;
#(
  parameter int MAX_COLUMNS = 32,
  parameter int MAX_ROWS    = 32,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]   s_tdata,   // sample
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [OUT_DATA_BITS-1:0]           m_tdata,   // peak_row, peak_column
  output logic                               m_tlast,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0]          cfg_index,
  input  logic [CFG_DATA_BITS-1:0]           cfg_data
);

  localparam int COL_BITS = $clog2(MAX_COLUMNS);
  localparam int ROW_BITS = $clog2(MAX_ROWS);
  localparam int CCW      = $clog2(MAX_COLUMNS + 1);
  localparam int RCW      = $clog2(MAX_ROWS + 1);
  localparam int ROW_RST  = (MAX_ROWS < 32) ? MAX_ROWS : 32;
  localparam int COL_RST  = (MAX_COLUMNS < 32) ? MAX_COLUMNS : 32;

  gpf_state_t state, state_next;

  logic [RCW-1:0]      row_count;
  logic [CCW-1:0]      column_count;
  logic [ROW_BITS-1:0] row_position;
  logic [COL_BITS-1:0] column_position;

  logic [ROW_BITS-1:0]           item_r;
  logic [COL_BITS-1:0]           item_c;
  logic signed [SAMPLE_BITS-1:0] sample_q;

  logic signed [SAMPLE_BITS-1:0] prev_left, prev_mid, up_mid, cur_l1, cur_l2;

  logic [2*SAMPLE_BITS-1:0] line_mem [MAX_COLUMNS];
  logic [2*SAMPLE_BITS-1:0] line_rdata;
  logic                     flag_mem [MAX_COLUMNS];
  logic                     flag_rdata;

  logic                run_any;
  logic [COL_BITS-1:0] run_last;
  logic                above_last, flush_go, final_flag;
  logic [COL_BITS-1:0] flush_last, flush_k;

  logic                out_valid, out_last;
  logic [PEAK_BITS-1:0] out_row, out_col;

  logic in_acc, cfg_acc, can_load;
  logic [COL_BITS-1:0] look_addr;
  logic pos_has_right;

  logic signed [SAMPLE_BITS-1:0] rd_newer, rd_older;
  logic r_ge1, r_ge2, c_ge1, c_ge2, has_right, last_row;
  logic up_ok, left_ok, end_ok, left_set, fin_set, any_mid, fin_any, flush_now;
  logic [COL_BITS-1:0] last_mid, fin_last;
  logic cur_flag, flush_done, load_above, load_flush;
  logic [RCW-1:0] cfg_rows;
  logic [CCW-1:0] cfg_cols;

  assign in_acc   = s_tvalid && s_tready;
  assign cfg_acc  = cfg_valid && cfg_ready;
  assign can_load = !out_valid || m_tready;

  // lookahead read address for the next column
  assign pos_has_right = (CCW'(column_position) + CCW'(1)) < column_count;
  assign look_addr     = pos_has_right ? (column_position + COL_BITS'(1)) : '0;

  assign rd_newer = line_rdata[SAMPLE_BITS-1:0];
  assign rd_older = line_rdata[2*SAMPLE_BITS-1:SAMPLE_BITS];

  always_comb begin
    r_ge1     = item_r != '0;
    r_ge2     = item_r > ROW_BITS'(1);
    c_ge1     = item_c != '0;
    c_ge2     = item_c > COL_BITS'(1);
    has_right = (CCW'(item_c) + CCW'(1)) < column_count;
    last_row  = (RCW'(item_r) + RCW'(1)) == row_count;

    up_ok = r_ge1 && (prev_mid >= sample_q)
         && (!r_ge2 || prev_mid >= up_mid)
         && (!c_ge1 || prev_mid >= prev_left)
         && (!has_right || prev_mid >= rd_newer);
    left_ok = (cur_l1 >= sample_q)
           && (!c_ge2 || cur_l1 >= cur_l2)
           && (!r_ge1 || cur_l1 >= prev_left);
    end_ok = (!c_ge1 || sample_q >= cur_l1)
          && (!r_ge1 || sample_q >= prev_mid);

    left_set  = last_row && c_ge1 && left_ok;
    any_mid   = run_any || left_set;
    last_mid  = left_set ? (item_c - COL_BITS'(1)) : run_last;
    fin_set   = last_row && !has_right && end_ok;
    fin_any   = any_mid || fin_set;
    fin_last  = fin_set ? item_c : last_mid;
    flush_now = last_row && !has_right && fin_any;
  end

  assign cur_flag   = ((CCW'(flush_k) + CCW'(1)) == column_count) ? final_flag : flag_rdata;
  assign flush_done = flush_k == flush_last;

  // register write clamping
  always_comb begin
    if (cfg_data == '0) begin
      cfg_rows = RCW'(1);
      cfg_cols = CCW'(1);
    end else begin
      cfg_rows = (32'(cfg_data) > MAX_ROWS) ? RCW'(MAX_ROWS) : RCW'(cfg_data);
      cfg_cols = (32'(cfg_data) > MAX_COLUMNS) ? CCW'(MAX_COLUMNS) : CCW'(cfg_data);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (in_acc) state_next = ST_DECIDE;
      ST_DECIDE: begin
        if (up_ok) state_next = ST_ABOVE;
        else if (flush_now) state_next = ST_FLUSH_RD;
        else state_next = ST_IDLE;
      end
      ST_ABOVE:    if (can_load) state_next = flush_go ? ST_FLUSH_RD : ST_IDLE;
      ST_FLUSH_RD: state_next = ST_FLUSH;
      ST_FLUSH: begin
        if (!cur_flag || can_load) state_next = flush_done ? ST_IDLE : ST_FLUSH_RD;
      end
      default:     state_next = ST_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    s_tready   = 1'b0;
    load_above = 1'b0;
    load_flush = 1'b0;
    unique case (state)
      ST_IDLE:     s_tready = 1'b1;
      ST_DECIDE:   ;
      ST_ABOVE:    load_above = can_load;
      ST_FLUSH_RD: ;
      ST_FLUSH:    load_flush = cur_flag && can_load;
      default:     ;
    endcase
  end

  assign cfg_ready = 1'b1;
  assign m_tvalid  = out_valid;
  assign m_tlast   = out_last;
  assign m_tdata   = OUT_DATA_BITS'({out_col, out_row});

  // line memory: read at accept, write back on decide
  always_ff @(posedge clk) begin
    if (in_acc) line_rdata <= line_mem[look_addr];
    if (state == ST_DECIDE) line_mem[item_c] <= {prev_mid, sample_q};
  end

  // last-row flag memory
  always_ff @(posedge clk) begin
    if (state == ST_DECIDE && last_row && c_ge1) flag_mem[item_c - COL_BITS'(1)] <= left_ok;
    if (state == ST_FLUSH_RD) flag_rdata <= flag_mem[flush_k];
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r   <= row_position;
      item_c   <= column_position;
      sample_q <= $signed(s_tdata[SAMPLE_BITS-1:0]);
    end
    if (state == ST_DECIDE) begin
      above_last <= !flush_now;
      flush_go   <= flush_now;
      flush_last <= fin_last;
      final_flag <= fin_set;
      run_last   <= last_mid;
      cur_l2     <= cur_l1;
      cur_l1     <= sample_q;
      if (has_right) begin
        prev_left <= prev_mid;
        prev_mid  <= rd_newer;
        up_mid    <= rd_older;
      end else if (column_count == CCW'(1)) begin
        prev_mid <= sample_q;
        up_mid   <= prev_mid;
      end else begin
        prev_mid <= rd_newer;
        up_mid   <= rd_older;
      end
    end
    if (load_above) begin
      out_row  <= PEAK_BITS'(item_r - ROW_BITS'(1));
      out_col  <= PEAK_BITS'(item_c);
      out_last <= above_last;
    end else if (load_flush) begin
      out_row  <= PEAK_BITS'(item_r);
      out_col  <= PEAK_BITS'(flush_k);
      out_last <= flush_done;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      row_count       <= RCW'(ROW_RST);
      column_count    <= CCW'(COL_RST);
      row_position    <= '0;
      column_position <= '0;
      run_any         <= 1'b0;
      flush_k         <= '0;
      out_valid       <= 1'b0;
    end else begin
      state <= state_next;
      if (load_above || load_flush) out_valid <= 1'b1;
      else if (m_tready) out_valid <= 1'b0;

      if (state == ST_DECIDE) begin
        flush_k   <= '0;
        run_any   <= (last_row && !has_right) ? 1'b0 : any_mid;
      end
      if (state == ST_FLUSH && (!cur_flag || can_load) && !flush_done) begin
        flush_k <= flush_k + COL_BITS'(1);
      end

      if (cfg_acc) begin
        if (cfg_index == REG_ROW_COUNT) begin
          row_count       <= cfg_rows;
          row_position    <= '0;
          column_position <= '0;
          run_any         <= 1'b0;
        end else if (cfg_index == REG_COLUMN_COUNT) begin
          column_count    <= cfg_cols;
          row_position    <= '0;
          column_position <= '0;
          run_any         <= 1'b0;
        end
      end else if (in_acc) begin
        if (pos_has_right) begin
          column_position <= column_position + COL_BITS'(1);
        end else begin
          column_position <= '0;
          if ((RCW'(row_position) + RCW'(1)) < row_count) begin
            row_position <= row_position + ROW_BITS'(1);
          end else begin
            row_position <= '0;
          end
        end
      end
    end
  end

endmodule
